@@ src/amc_pkg.sv @@
package amc_pkg;

  localparam int unsigned OPND_W    = 10;
  localparam int unsigned OPER_W    = 4;
  localparam int unsigned IN_VAL_W  = 32;
  localparam int unsigned PC_OUT_W  = 11;
  localparam int unsigned VAL_OUT_W = 32;
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic [OPER_W-1:0] {
    OP_LOAD   = 4'd1,
    OP_ADD    = 4'd2,
    OP_STORE  = 4'd3,
    OP_SUB    = 4'd4,
    OP_INPUT  = 4'd5,
    OP_OUTPUT = 4'd6,
    OP_END    = 4'd7,
    OP_JUMP   = 4'd8,
    OP_SKIPZ  = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_END    = 2'd1,
    ST_BADOP  = 2'd2,
    ST_OFFEND = 2'd3
  } status_t;

  typedef struct packed {
    logic [OPND_W-1:0] operand;
    logic [OPER_W-1:0] operation;
  } prog_word_t;

endpackage

@@ src/accumulator_machine_core.sv @@
// Channel  Dir  Group                   Contents
// request  in   s_tvalid/s_tready       tuser: opcode; tdata: index, operation, operand, in_value
// result   out  m_tvalid/m_tready       tuser: out_valid; tdata: pc, acc, out_value, status
//
// Each request passes through program store read, then data store read, then execute.
// A new request is taken only once the previous one has left the program store read;
// the next fetch address is forwarded from the execute stage. After reset a clearing pass
// over max(PROG_DEPTH, DATA_DEPTH) addresses zeroes both stores, with s_tready low.
// A stalled result holds execute; empty stages admit the next request while a result waits.
module accumulator_machine_core #(
  parameter int PROG_DEPTH = 1024,
  parameter int DATA_DEPTH = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [9:0] load_index, [13:10] load_operation, [23:14] load_operand, [55:24] in_value
  input  logic [amc_pkg::S_TDATA_W-1:0]  s_tdata,
  // [0] opcode
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [10:0] pc, [42:11] acc, [74:43] out_value, [76:75] status, [79:77] zero
  output logic [amc_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] out_valid
  output logic                           m_tuser
);
  import amc_pkg::*;

  localparam int PA_W      = $clog2(PROG_DEPTH);
  localparam int DA_W      = $clog2(DATA_DEPTH);
  localparam int PC_MIN_W  = $clog2(PROG_DEPTH + 2);
  localparam int PC_W      = (PC_MIN_W > PC_OUT_W) ? PC_MIN_W : PC_OUT_W;
  localparam int LI_W      = (PA_W > OPND_W) ? PA_W : OPND_W;
  localparam int DO_W      = (DA_W > OPND_W) ? DA_W : OPND_W;
  localparam int CLR_DEPTH = (PROG_DEPTH > DATA_DEPTH) ? PROG_DEPTH : DATA_DEPTH;
  localparam int CLR_W     = $clog2(CLR_DEPTH);
  localparam logic [PC_W-1:0]  PC_END   = PC_W'(PROG_DEPTH);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_DEPTH - 1);

  prog_word_t            prog_mem [PROG_DEPTH];
  logic [WORD_WIDTH-1:0] data_mem [DATA_DEPTH];

  logic                  clr_busy;
  logic [CLR_W-1:0]      clr_idx;

  logic [OPND_W-1:0]     in_index;
  logic [OPER_W-1:0]     in_oper;
  logic [OPND_W-1:0]     in_operand;
  logic signed [IN_VAL_W-1:0] in_value;
  logic [LI_W-1:0]       in_index_ext;
  logic                  accept;

  logic                  s1_v;
  kind_t                 s1_kind;
  logic signed [IN_VAL_W-1:0] s1_in_value;
  prog_word_t            prog_q;
  logic                  s1_go;

  logic                  s2_v;
  kind_t                 s2_kind;
  logic signed [IN_VAL_W-1:0] s2_in_value;
  logic [OPER_W-1:0]     s2_op;
  logic [OPND_W-1:0]     s2_operand;
  logic [DO_W-1:0]       s2_operand_ext;
  logic [DO_W-1:0]       rd_operand_ext;
  logic [WORD_WIDTH-1:0] data_q;
  logic                  s2_go;
  logic                  s2_fire;

  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  logic [PC_W-1:0]       pc_fwd;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] acc_next;
  logic [WORD_WIDTH-1:0] acc_in;
  logic [WORD_WIDTH-1:0] dval;
  logic                  d_ok;
  status_t               halt;
  status_t               halt_next;
  logic                  emit;
  logic                  st_we;

  logic                  o_v;
  logic [PC_OUT_W-1:0]   o_pc;
  logic [VAL_OUT_W-1:0]  o_acc;
  logic                  o_outv;
  logic [VAL_OUT_W-1:0]  o_outval;
  logic [1:0]            o_status;

  assign in_index     = s_tdata[9:0];
  assign in_oper      = s_tdata[13:10];
  assign in_operand   = s_tdata[23:14];
  assign in_value     = s_tdata[55:24];
  assign in_index_ext = LI_W'(in_index);

  assign s2_go    = !o_v || m_tready;
  assign s2_fire  = s2_v && s2_go;
  assign s1_go    = s1_v && (!s2_v || s2_go);
  assign s_tready = !clr_busy && !s1_v && (!s2_v || s2_go);
  assign accept   = s_tvalid && s_tready;
  assign pc_fwd   = s2_fire ? pc_next : pc;

  assign rd_operand_ext = DO_W'(prog_q.operand);
  assign s2_operand_ext = DO_W'(s2_operand);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else if (clr_busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == CLR_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      if (clr_idx < PROG_DEPTH) begin
        prog_mem[clr_idx[PA_W-1:0]] <= '0;
      end
    end else if (accept && kind_t'(s_tuser) == KIND_LOAD && in_index < PROG_DEPTH) begin
      prog_mem[in_index_ext[PA_W-1:0]] <= '{operand: in_operand, operation: in_oper};
    end
    if (accept) begin
      prog_q <= prog_mem[pc_fwd[PA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      if (clr_idx < DATA_DEPTH) begin
        data_mem[clr_idx[DA_W-1:0]] <= '0;
      end
    end else if (s2_fire && st_we) begin
      data_mem[s2_operand_ext[DA_W-1:0]] <= acc;
    end
    if (s1_go) begin
      data_q <= data_mem[rd_operand_ext[DA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (accept) begin
        s1_v <= 1'b1;
      end else if (s1_go) begin
        s1_v <= 1'b0;
      end
      if (s1_go) begin
        s2_v <= 1'b1;
      end else if (s2_fire) begin
        s2_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= kind_t'(s_tuser);
      s1_in_value <= in_value;
    end
    if (s1_go) begin
      s2_kind     <= s1_kind;
      s2_in_value <= s1_in_value;
      s2_op       <= prog_q.operation;
      s2_operand  <= prog_q.operand;
    end
  end

  assign d_ok   = s2_operand < DATA_DEPTH;
  assign dval   = d_ok ? data_q : '0;
  assign acc_in = WORD_WIDTH'(s2_in_value);

  always_comb begin
    pc_next   = pc;
    acc_next  = acc;
    halt_next = halt;
    emit      = 1'b0;
    st_we     = 1'b0;
    if (s2_kind == KIND_STEP && halt == ST_RUN) begin
      if (pc >= PC_END) begin
        halt_next = ST_OFFEND;
      end else begin
        pc_next = pc + 1'b1;
        case (s2_op)
          OP_LOAD:   acc_next = dval;
          OP_ADD:    acc_next = acc + dval;
          OP_STORE:  st_we = d_ok;
          OP_SUB:    acc_next = acc - dval;
          OP_INPUT:  acc_next = acc_in;
          OP_OUTPUT: emit = 1'b1;
          OP_END: begin
            pc_next   = PC_END;
            halt_next = ST_END;
          end
          OP_JUMP:   pc_next = PC_W'(s2_operand);
          OP_SKIPZ: begin
            if (acc == '0) begin
              pc_next = pc + 2'd2;
            end
          end
          default: begin
            pc_next   = PC_END;
            halt_next = ST_BADOP;
          end
        endcase
        if (halt_next == ST_RUN && pc_next >= PC_END) begin
          halt_next = ST_OFFEND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= '0;
      acc  <= '0;
      halt <= ST_RUN;
    end else if (s2_fire) begin
      pc   <= pc_next;
      acc  <= acc_next;
      halt <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (s2_fire) begin
      o_v <= 1'b1;
    end else if (m_tready) begin
      o_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      o_pc     <= pc_next[PC_OUT_W-1:0];
      o_acc    <= VAL_OUT_W'(acc_next);
      o_outv   <= emit;
      o_outval <= emit ? VAL_OUT_W'(acc) : '0;
      o_status <= halt_next;
    end
  end

  assign m_tvalid = o_v;
  assign m_tuser  = o_outv;
  assign m_tdata  = {3'b000, o_status, o_outval, o_acc, o_pc};

endmodule

@@ verif/tb_accumulator_machine_core.sv @@
module tb_accumulator_machine_core;
  import amc_pkg::*;

  localparam int unsigned PROG_WORDS = 1024;
  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned REQUEST_COUNT = 1250;
  localparam int unsigned DRAIN_POINT = 700;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [OPER_W-1:0] OP_NONE = 4'd0;
  localparam logic [OPER_W-1:0] OP_BAD = 4'd15;

  typedef struct {
    logic [PC_OUT_W-1:0] pc;
    logic [VAL_OUT_W-1:0] acc;
    logic emit_valid;
    logic [VAL_OUT_W-1:0] emit_value;
    status_t status;
  } machine_result_t;

  typedef struct {
    kind_t kind;
    logic [OPND_W-1:0] idx;
    logic [OPER_W-1:0] oper;
    logic [OPND_W-1:0] opnd;
    logic [IN_VAL_W-1:0] value;
    bit typed;
    machine_result_t want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  logic [OPER_W-1:0] prog_oper[PROG_WORDS];
  logic [OPND_W-1:0] prog_opnd[PROG_WORDS];
  logic [VAL_OUT_W-1:0] data_words[DATA_WORDS];
  int unsigned pc_q;
  logic [VAL_OUT_W-1:0] acc_q;
  status_t halt_q;

  machine_result_t pending_results[$];
  directed_row_t plan[$];
  machine_result_t none_r;
  int unsigned requests_sent;
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned stall_left;
  bit no_gaps;

  accumulator_machine_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic machine_result_t execute_request(kind_t kind, logic [OPND_W-1:0] idx,
                                                      logic [OPER_W-1:0] oper,
                                                      logic [OPND_W-1:0] opnd,
                                                      logic [IN_VAL_W-1:0] value);
    machine_result_t r;
    logic [OPER_W-1:0] op;
    logic [OPND_W-1:0] addr;
    r.emit_valid = 1'b0;
    r.emit_value = '0;
    if (kind == KIND_LOAD) begin
      prog_oper[idx] = oper;
      prog_opnd[idx] = opnd;
    end else begin
      if (halt_q == ST_RUN && pc_q >= PROG_WORDS) halt_q = ST_OFFEND;
      if (halt_q == ST_RUN) begin
        op = prog_oper[pc_q];
        addr = prog_opnd[pc_q];
        pc_q++;
        case (op)
          OP_LOAD: acc_q = data_words[addr];
          OP_ADD: acc_q = acc_q + data_words[addr];
          OP_STORE: data_words[addr] = acc_q;
          OP_SUB: acc_q = acc_q - data_words[addr];
          OP_INPUT: acc_q = value;
          OP_OUTPUT: begin
            r.emit_valid = 1'b1;
            r.emit_value = acc_q;
          end
          OP_END: begin
            pc_q = PROG_WORDS;
            halt_q = ST_END;
          end
          OP_JUMP: pc_q = addr;
          OP_SKIPZ: begin
            if (acc_q == '0) pc_q++;
          end
          default: begin
            pc_q = PROG_WORDS;
            halt_q = ST_BADOP;
          end
        endcase
        if (halt_q == ST_RUN && pc_q >= PROG_WORDS) halt_q = ST_OFFEND;
      end
    end
    r.pc = pc_q[PC_OUT_W-1:0];
    r.acc = acc_q;
    r.status = halt_q;
    return r;
  endfunction

  // True when executing oper at the current counter leaves the machine running.
  function automatic bit keeps_running(logic [OPER_W-1:0] oper);
    case (oper)
      OP_JUMP: return 1'b1;
      OP_SKIPZ: return pc_q + 1 + ((acc_q == '0) ? 1 : 0) < PROG_WORDS;
      OP_LOAD, OP_ADD, OP_STORE, OP_SUB, OP_INPUT, OP_OUTPUT: return pc_q + 1 < PROG_WORDS;
      default: return 1'b0;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_row(kind_t kind, logic [OPND_W-1:0] idx,
                                  logic [OPER_W-1:0] oper, logic [OPND_W-1:0] opnd,
                                  logic [IN_VAL_W-1:0] value, bit typed,
                                  logic [PC_OUT_W-1:0] pc, logic [VAL_OUT_W-1:0] acc,
                                  logic emit_valid, logic [VAL_OUT_W-1:0] emit_value,
                                  status_t status);
    directed_row_t row;
    row.kind = kind;
    row.idx = idx;
    row.oper = oper;
    row.opnd = opnd;
    row.value = value;
    row.typed = typed;
    row.want.pc = pc;
    row.want.acc = acc;
    row.want.emit_valid = emit_valid;
    row.want.emit_value = emit_value;
    row.want.status = status;
    plan.push_back(row);
  endfunction

  task automatic send_request(input kind_t kind, input logic [OPND_W-1:0] idx,
                              input logic [OPER_W-1:0] oper, input logic [OPND_W-1:0] opnd,
                              input logic [IN_VAL_W-1:0] value, input bit typed,
                              input machine_result_t want);
    int unsigned gap;
    machine_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {value, opnd, oper, idx};
    do @(posedge clk); while (!s_tready);
    predicted = execute_request(kind, idx, oper, opnd, value);
    pending_results.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  always @(posedge clk) begin
    machine_result_t want;
    int unsigned r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: pc %0d acc %h", m_tdata[10:0], m_tdata[42:11]);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[10:0] !== want.pc) begin
          $error("pc: expected %0d, got %0d", want.pc, m_tdata[10:0]);
          failures++;
        end
        if (m_tdata[42:11] !== want.acc) begin
          $error("acc: expected %h, got %h", want.acc, m_tdata[42:11]);
          failures++;
        end
        if (m_tuser !== want.emit_valid) begin
          $error("out_valid: expected %0b, got %0b", want.emit_valid, m_tuser);
          failures++;
        end
        if (m_tdata[74:43] !== want.emit_value) begin
          $error("out_value: expected %h, got %h", want.emit_value, m_tdata[74:43]);
          failures++;
        end
        if (m_tdata[76:75] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[76:75]);
          failures++;
        end
      end
    end
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (no_gaps || r < 65) begin
      m_tready <= 1'b1;
    end else if (r < 94) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(8, 40);
    end
  end

  initial begin
    logic [OPER_W-1:0] oper;
    logic [OPND_W-1:0] opnd;
    bit drained;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    requests_sent = 0;
    failures = 0;
    cycle_count = 0;
    stall_left = 0;
    no_gaps = 1'b0;
    drained = 1'b0;
    none_r.pc = '0;
    none_r.acc = '0;
    none_r.emit_valid = 1'b0;
    none_r.emit_value = '0;
    none_r.status = ST_RUN;
    for (int i = 0; i < PROG_WORDS; i++) begin
      prog_oper[i] = '0;
      prog_opnd[i] = '0;
    end
    for (int i = 0; i < DATA_WORDS; i++) data_words[i] = '0;
    pc_q = 0;
    acc_q = '0;
    halt_q = ST_RUN;

    // program: input, store, add, output, subtract, skip if zero, load, jump back
    add_row(KIND_LOAD, 10'd0, OP_INPUT, 10'd0, 32'h0, 1'b1,
            11'd0, 32'h0, 1'b0, 32'h0, ST_RUN);
    add_row(KIND_LOAD, 10'd1023, OP_BAD, 10'd1023, 32'hFFFF_FFFF, 1'b1,
            11'd0, 32'h0, 1'b0, 32'h0, ST_RUN);
    add_row(KIND_LOAD, 10'd1, OP_STORE, 10'd1023, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd2, OP_ADD, 10'd1023, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd3, OP_OUTPUT, 10'd0, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd4, OP_SUB, 10'd1023, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd5, OP_SKIPZ, 10'd0, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd6, OP_LOAD, 10'd1023, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_LOAD, 10'd7, OP_JUMP, 10'd0, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h7FFF_FFFF, 1'b1,
            11'd1, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_RUN);
    add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h8000_0000, 1'b0, 0, 0, 0, 0, ST_RUN);
    add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h0, 1'b1,
            11'd3, 32'hFFFF_FFFE, 1'b0, 32'h0, ST_RUN);
    add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h0, 1'b1,
            11'd4, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFE, ST_RUN);
    for (int i = 0; i < 4; i++)
      add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);
    // second pass with zero: the skip is taken
    for (int i = 0; i < 7; i++)
      add_row(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h0, 1'b0, 0, 0, 0, 0, ST_RUN);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_request(plan[i].kind, plan[i].idx, plan[i].oper, plan[i].opnd, plan[i].value,
                   plan[i].typed, plan[i].want);

    while (requests_sent < REQUEST_COUNT) begin
      no_gaps = ((requests_sent / 100) % 4) == 2;
      if (!drained && requests_sent >= DRAIN_POINT) begin
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(KIND_LOAD, 10'($urandom), 4'($urandom), 10'($urandom), $urandom,
                     1'b0, none_r);
      end else begin
        // patch the word at the counter so that the machine keeps running
        if (!keeps_running(prog_oper[pc_q])) begin
          do oper = 4'($urandom_range(OP_LOAD, OP_SKIPZ));
          while (oper == OP_END || !keeps_running(oper));
          if (oper == OP_JUMP || $urandom_range(0, 4) == 0) opnd = 10'($urandom);
          else opnd = 10'($urandom_range(0, 15));
          send_request(KIND_LOAD, pc_q[OPND_W-1:0], oper, opnd, $urandom, 1'b0, none_r);
        end
        send_request(KIND_STEP, 10'($urandom), 4'($urandom), 10'($urandom), pick_value(),
                     1'b0, none_r);
      end
    end

    no_gaps = 1'b0;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // halt the machine one of three ways, then poke it while halted
    case ($urandom_range(0, 2))
      0: send_request(KIND_LOAD, pc_q[OPND_W-1:0], OP_END, 10'($urandom), 32'h0, 1'b0,
                      none_r);
      1: begin
        oper = ($urandom_range(0, 6) == 0) ? OP_NONE : OP_BAD - 4'($urandom_range(0, 5));
        send_request(KIND_LOAD, pc_q[OPND_W-1:0], oper, 10'($urandom), 32'h0, 1'b0, none_r);
      end
      default: begin
        send_request(KIND_LOAD, pc_q[OPND_W-1:0], OP_JUMP, 10'd1023, 32'h0, 1'b0, none_r);
        send_request(KIND_LOAD, 10'd1023, OP_OUTPUT, 10'd0, 32'h0, 1'b0, none_r);
        send_request(KIND_STEP, 10'd0, OP_NONE, 10'd0, 32'h0, 1'b0, none_r);
      end
    endcase
    send_request(KIND_STEP, 10'd0, OP_NONE, 10'd0, $urandom, 1'b0, none_r);
    send_request(KIND_STEP, 10'd0, OP_NONE, 10'd0, $urandom, 1'b0, none_r);
    send_request(KIND_LOAD, 10'($urandom), OP_INPUT, 10'($urandom), $urandom, 1'b0, none_r);
    send_request(KIND_STEP, 10'd0, OP_NONE, 10'd0, $urandom, 1'b0, none_r);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
